@@ design/smf_pkg.sv @@
// Shared types and constants for the streaming first-match substring search.
// Used by every module of the block; depends on nothing.
package smf_pkg;

    // Needle window size and haystack length limit
    localparam int NEEDLE_MAX   = 16;
    localparam int HAYSTACK_MAX = 65536;
    localparam int COUNT_W      = $clog2(HAYSTACK_MAX + 1);
    localparam int NIDX_W       = $clog2(NEEDLE_MAX);
    localparam int LEN_W        = 5;
    localparam int START_W      = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NEEDLE_LOW  = 2'd0,
        CFG_NEEDLE_HIGH = 2'd1,
        CFG_NEEDLE_LEN  = 2'd2
    } t_cfg_index;

    // One result request
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] match_start;
        logic               too_long;
    } t_result;

endpackage

@@ design/smf_cell.sv @@
// One window cell: holds one recent haystack byte, passes it to its neighbor.
// Compares the byte it takes in against its needle byte. Depends on smf_pkg.
module smf_cell
    import smf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte_in,
    input  logic [7:0] i_needle_byte,
    input  logic       i_in_use,
    output logic [7:0] o_byte,
    output logic       o_eq
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Compare the incoming byte; cells past the needle length always agree
    assign o_eq = !i_in_use || (i_byte_in == i_needle_byte);

    // Take the neighbor's byte on a shift, drop it at the end of a haystack
    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = 8'd0;
        end else if (i_shift) begin
            n_byte = i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

@@ design/smf_out_buf.sv @@
// Output register with one skid entry for result requests.
// Lets the search take a byte while a result waits. Depends on smf_pkg.
module smf_out_buf
    import smf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_full
);

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Refill the output from the skid entry first, park new requests behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_res_valid;
                n_skid       = i_res;
            end else begin
                n_out_valid = i_res_valid;
                n_out       = i_res;
            end
        end else if (i_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule

@@ design/substring_first_match.sv @@
// Top level of the streaming first-match substring search.
// Instantiates the window cell chain and the output buffer; depends on smf_pkg.
//
// Haystack bytes enter one per clock and a result request is registered from
// the byte that causes it: one per haystack, either found with the start offset
// of the first match, not found on the final byte, or too long when a byte
// arrives after 65536 bytes without a match. The window is a chain of 16 byte
// cells that shift on each taken byte of a running search and compare their
// incoming byte against the needle in the same cycle, so the block sustains
// one byte per clock. Input stalls only when both the output register and its
// skid entry hold results. Needle registers may be written whenever no byte is
// in flight; a needle length of zero or above 16 never matches.
module substring_first_match
    import smf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // haystack input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    // result output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic [START_W-1:0] o_match_start,
    output logic               o_too_long,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    logic [63:0]        r_needle_low;
    logic [63:0]        r_needle_high;
    logic [LEN_W-1:0]   r_len;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_done;
    logic               n_done;

    logic [7:0]         needle    [NEEDLE_MAX];
    logic [7:0]         win       [NEEDLE_MAX];
    logic [7:0]         shift_in  [NEEDLE_MAX];
    logic [7:0]         needle_sel[NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] in_use;
    logic [NEEDLE_MAX-1:0] eq;

    logic               in_acc;
    logic               active;
    logic               over;
    logic               shift;
    logic               clear;
    logic               count_ok;
    logic               len_ok;
    logic               match;
    logic [COUNT_W-1:0] count_new;
    logic               res_valid;
    t_result            res;
    t_result            out_res;
    logic               skid_full;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= 64'd0;
            r_needle_high <= 64'd0;
            r_len         <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NEEDLE_LOW:  r_needle_low  <= i_cfg_data;
                CFG_NEEDLE_HIGH: r_needle_high <= i_cfg_data;
                CFG_NEEDLE_LEN:  r_len         <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Split the needle registers into bytes
    always_comb begin
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            if (k < 8) begin
                needle[k] = r_needle_low[8*k +: 8];
            end else begin
                needle[k] = r_needle_high[8*(k-8) +: 8];
            end
        end
    end

    // Request handshake and search control
    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = skid_full;
    assign count_ok  = r_count < COUNT_W'(HAYSTACK_MAX);
    assign active    = in_acc && !r_done;
    assign over      = active && !count_ok;
    assign shift     = active && count_ok;
    assign clear     = in_acc && i_last_byte;
    assign count_new = r_count + COUNT_W'(1);
    assign len_ok    = (r_len != '0) && (r_len <= LEN_W'(NEEDLE_MAX));
    assign match     = len_ok && (count_new >= COUNT_W'(r_len)) && (&eq);

    // Chain of window cells; cell j compares against needle byte len-1-j
    genvar j;
    generate
        for (j = 0; j < NEEDLE_MAX; j++) begin : g_cell
            logic [LEN_W-1:0] sel_idx;

            if (j == 0) begin : g_head
                assign shift_in[j] = i_data_byte;
            end else begin : g_link
                assign shift_in[j] = win[j-1];
            end

            assign sel_idx       = r_len - LEN_W'(j) - LEN_W'(1);
            assign in_use[j]     = LEN_W'(j) < r_len;
            assign needle_sel[j] = needle[sel_idx[NIDX_W-1:0]];

            smf_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_shift       (shift),
                .i_clear       (clear),
                .i_byte_in     (shift_in[j]),
                .i_needle_byte (needle_sel[j]),
                .i_in_use      (in_use[j]),
                .o_byte        (win[j]),
                .o_eq          (eq[j])
            );
        end
    endgenerate

    // Build the result request for this byte
    always_comb begin
        res       = '0;
        res_valid = 1'b0;
        if (over) begin
            res_valid    = 1'b1;
            res.too_long = 1'b1;
        end else if (shift && match) begin
            res_valid       = 1'b1;
            res.found       = 1'b1;
            res.match_start = START_W'(count_new - COUNT_W'(r_len));
        end else if (shift && i_last_byte) begin
            res_valid = 1'b1;
        end
    end

    // Advance the byte count and search state; drop both at the last byte
    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        if (clear) begin
            n_count = '0;
            n_done  = 1'b0;
        end else begin
            if (shift) begin
                n_count = count_new;
            end
            if (over || (shift && match)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    smf_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_res       (out_res),
        .o_full      (skid_full)
    );

    assign o_found       = out_res.found;
    assign o_match_start = out_res.match_start;
    assign o_too_long    = out_res.too_long;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid entry holds a result while the output is empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(HAYSTACK_MAX))
        else $error("byte count past the haystack limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_byte) |=> (r_count == '0 && !r_done))
        else $error("search state not cleared after the last byte");

    a_done_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(i_in_valid && !o_in_stall && i_last_byte)) |=> $stable(r_count))
        else $error("byte count moved after the search ended");
`endif

endmodule
